>>> rtl/dcglcd_pkg.sv
// dcglcd_pkg: shared types, command codes and defaults for the dual-chip
// graphic lcd controller; no dependencies
package dcglcd_pkg;

  localparam int unsigned PagesDef   = 8;
  localparam int unsigned ColumnsDef = 64;
  localparam int unsigned ChipsDef   = 2;

  localparam int unsigned PageW   = 3;
  localparam int unsigned ColW    = 6;
  localparam int unsigned ByteW   = 8;
  // widest display ram address of one chip (8 pages x 64 columns)
  localparam int unsigned RamAwMax = 9;

  typedef enum logic [1:0] {
    OP_CMD    = 2'd0,
    OP_WRITE  = 2'd1,
    OP_STATUS = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  localparam logic [7:0] CMD_OFF       = 8'h3e;
  localparam logic [7:0] CMD_ON        = 8'h3f;
  localparam logic [7:0] CMD_COL       = 8'h40;
  localparam logic [7:0] CMD_COL_MASK  = 8'hc0;
  localparam logic [7:0] CMD_PAGE      = 8'hb8;
  localparam logic [7:0] CMD_PAGE_MASK = 8'hf8;
  localparam logic [7:0] CMD_START     = 8'hc0;
  localparam logic [7:0] STATUS_BUSY   = 8'h80;
  localparam logic [7:0] STATUS_OFF    = 8'h20;

  // ram clearing sweep after reset
  typedef struct packed {
    logic                active;
    logic [RamAwMax-1:0] addr;
  } clr_t;

  // one bus access as seen by a chip
  typedef struct packed {
    logic             sel;
    op_e              op;
    logic [ByteW-1:0] data;
  } acc_t;

endpackage

>>> rtl/dcglcd_in_if.sv
// dcglcd_in_if: valid/ready channel carrying one bus access
// depends on nothing
interface dcglcd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [1:0] chip_select;
  logic [7:0] bus_byte;

  modport source (output valid, output operation, output chip_select, output bus_byte,
                  input ready);
  modport sink   (input valid, input operation, input chip_select, input bus_byte,
                  output ready);
endinterface

>>> rtl/dcglcd_out_if.sv
// dcglcd_out_if: valid/ready channel carrying one read result
// depends on nothing
interface dcglcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;

  modport source (output valid, output read_byte, input ready);
  modport sink   (input valid, input read_byte, output ready);
endinterface

>>> rtl/dcglcd_chip.sv
// dcglcd_chip: one controller chip, display ram plus pointer, flag and latch
// registers; depends on dcglcd_pkg
module dcglcd_chip #(
  parameter int unsigned PAGES   = dcglcd_pkg::PagesDef,
  parameter int unsigned COLUMNS = dcglcd_pkg::ColumnsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dcglcd_pkg::clr_t             clr_i,
  input  dcglcd_pkg::acc_t             acc_i,
  output logic [dcglcd_pkg::ByteW-1:0] rd_byte_o
);
  import dcglcd_pkg::*;

  localparam int unsigned Depth = PAGES * COLUMNS;
  localparam int unsigned AddrW = $clog2(Depth);

  logic [ByteW-1:0] mem [Depth];
  logic [ByteW-1:0] rdata_q;

  logic [PageW-1:0] page_q, page_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [ColW-1:0]  start_q, start_d;
  logic             on_q, on_d;
  logic [ByteW-1:0] latch_q, latch_d;
  logic             pend_q, pend_d;

  logic             in_ram;
  logic [ColW:0]    col_inc;
  logic [ColW-1:0]  col_next;
  logic [9:0]       lin;
  logic [AddrW-1:0] acc_addr;
  logic [ByteW-1:0] latch_eff;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_addr;
  logic [ByteW-1:0] mem_wdata;

  assign in_ram   = ({1'b0, page_q} < (PageW + 1)'(PAGES)) &&
                    ({1'b0, col_q} < (ColW + 1)'(COLUMNS));
  assign col_inc  = {1'b0, col_q} + (ColW + 1)'(1);
  assign col_next = (col_inc >= (ColW + 1)'(COLUMNS)) ? '0 : col_inc[ColW-1:0];
  assign lin      = 10'(page_q) * 10'(COLUMNS) + 10'(col_q);
  assign acc_addr = lin[AddrW-1:0];
  // latch contents still in flight from the ram come from its read register
  assign latch_eff = pend_q ? rdata_q : latch_q;

  always_comb begin
    page_d    = page_q;
    col_d     = col_q;
    start_d   = start_q;
    on_d      = on_q;
    latch_d   = pend_q ? rdata_q : latch_q;
    pend_d    = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = acc_addr;
    mem_wdata = acc_i.data;
    rd_byte_o = '0;
    if (clr_i.active) begin
      mem_we    = 1'b1;
      mem_addr  = clr_i.addr[AddrW-1:0];
      mem_wdata = '0;
    end else if (acc_i.sel) begin
      case (acc_i.op)
        OP_CMD: begin
          if (acc_i.data == CMD_OFF) begin
            on_d = 1'b0;
          end else if (acc_i.data == CMD_ON) begin
            on_d = 1'b1;
          end else if ((acc_i.data & CMD_COL_MASK) == CMD_COL) begin
            col_d = acc_i.data[ColW-1:0];
          end else if ((acc_i.data & CMD_PAGE_MASK) == CMD_PAGE) begin
            page_d = acc_i.data[PageW-1:0];
          end else if ((acc_i.data & CMD_COL_MASK) == CMD_START) begin
            start_d = acc_i.data[ColW-1:0];
          end
        end
        OP_WRITE: begin
          mem_we = in_ram;
          col_d  = col_next;
        end
        OP_STATUS: begin
          rd_byte_o = on_q ? '0 : STATUS_OFF;
        end
        OP_READ: begin
          rd_byte_o = latch_eff;
          col_d     = col_next;
          if (in_ram) begin
            mem_re = 1'b1;
            pend_d = 1'b1;
          end else begin
            latch_d = '0;
          end
        end
        default: begin
          rd_byte_o = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q  <= '0;
      col_q   <= '0;
      start_q <= '0;
      on_q    <= 1'b0;
      latch_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      page_q  <= page_d;
      col_q   <= col_d;
      start_q <= start_d;
      on_q    <= on_d;
      latch_q <= latch_d;
      pend_q  <= pend_d;
    end
  end

endmodule

>>> rtl/dcglcd_rsp_q.sv
// dcglcd_rsp_q: two-entry result queue between the chips and the output channel
// depends on dcglcd_pkg and dcglcd_out_if
module dcglcd_rsp_q (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [dcglcd_pkg::ByteW-1:0] data_i,
  output logic                         full_o,
  dcglcd_out_if.source                 rsp_o
);
  import dcglcd_pkg::*;

  logic [ByteW-1:0] buf_q [2];
  logic             wr_q, wr_d, rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop;

  assign pop           = rsp_o.valid && rsp_o.ready;
  assign rsp_o.valid   = (cnt_q != 2'd0);
  assign rsp_o.read_byte = buf_q[rd_q];
  assign full_o        = (cnt_q == 2'd2);

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/dual_chip_graphic_lcd_controller.sv
// dual_chip_graphic_lcd_controller: top level, chips, clearing sweep and result queue
// depends on dcglcd_pkg, dcglcd_in_if, dcglcd_out_if, dcglcd_chip, dcglcd_rsp_q
//
//   port    dir  carries
//   req_i   in   operation, chip_select, bus_byte (one bus access)
//   rsp_o   out  read_byte (one per status or data read)
//
// one bus access per cycle while req_i.ready is high; each chip touches one byte of its own
// ram port and its pointer registers, ram read data is registered and feeds the latch path.
// after reset each chip ram is swept to zero, req_i.ready low meanwhile. results go
// through a two-entry queue; besides the sweep, req_i.ready drops only when that queue
// is full.
module dual_chip_graphic_lcd_controller #(
  parameter int unsigned PAGES   = dcglcd_pkg::PagesDef,
  parameter int unsigned COLUMNS = dcglcd_pkg::ColumnsDef,
  parameter int unsigned CHIPS   = dcglcd_pkg::ChipsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dcglcd_in_if.sink    req_i,
  dcglcd_out_if.source rsp_o
);
  import dcglcd_pkg::*;

  localparam int unsigned Depth = PAGES * COLUMNS;
  localparam int unsigned AddrW = $clog2(Depth);

  logic             clearing_q, clearing_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  clr_t             clr;
  acc_t             acc [CHIPS];
  logic [ByteW-1:0] chip_rd [CHIPS];
  logic [ByteW-1:0] rd_or;
  logic             accept, is_read, q_full;

  assign req_i.ready = !clearing_q && !q_full;
  assign accept      = req_i.valid && req_i.ready;
  assign is_read     = (op_e'(req_i.operation) == OP_STATUS) ||
                       (op_e'(req_i.operation) == OP_READ);

  always_comb begin
    clr.active = clearing_q;
    clr.addr   = RamAwMax'(clr_cnt_q);
  end

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == AddrW'(Depth - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  for (genvar c = 0; c < CHIPS; c++) begin : g_chip
    always_comb begin
      acc[c].sel  = accept && req_i.chip_select[c];
      acc[c].op   = op_e'(req_i.operation);
      acc[c].data = req_i.bus_byte;
    end

    dcglcd_chip #(
      .PAGES  (PAGES),
      .COLUMNS(COLUMNS)
    ) u_chip (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .clr_i    (clr),
      .acc_i    (acc[c]),
      .rd_byte_o(chip_rd[c])
    );
  end

  // both selected chips drive the bus on reads
  always_comb begin
    rd_or = '0;
    for (int c = 0; c < CHIPS; c++) begin
      rd_or = rd_or | chip_rd[c];
    end
  end

  dcglcd_rsp_q u_rsp_q (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(accept && is_read),
    .data_i(rd_or),
    .full_o(q_full),
    .rsp_o (rsp_o)
  );

`ifndef SYNTHESIS
  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !req_i.ready)
    else $error("item accepted during ram clear");

  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_read) |=> rsp_o.valid)
    else $error("read item produced no result");

  a_idle_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!rsp_o.valid && !(accept && is_read)) |=> !rsp_o.valid)
    else $error("result appeared without a read");
`endif

endmodule

>>> sim/dual_chip_graphic_lcd_controller_tb.sv
// self-checking testbench for dual_chip_graphic_lcd_controller: random bus accesses,
// an in-bench model of both chips predicts every status and data read
// depends on dcglcd_pkg, dcglcd_in_if, dcglcd_out_if and the rtl top level
module dual_chip_graphic_lcd_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dcglcd_pkg::*;

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned RandItems  = 800;
  localparam int unsigned MaxWait    = 17;
  localparam int unsigned DrainWait  = 20;
  localparam int unsigned HoldAfter  = 150;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    op_e              op;
    logic [1:0]       cs;
    logic [ByteW-1:0] data;
  } bus_item_t;

  logic clk_i;
  logic rst_ni;

  dcglcd_in_if  req_if ();
  dcglcd_out_if rsp_if ();

  dual_chip_graphic_lcd_controller DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // chip state as the bus sees it
  bit [ByteW-1:0] lcd_ram   [ChipsDef][PagesDef][ColumnsDef];
  bit [PageW-1:0] page_ptr  [ChipsDef];
  bit [ColW-1:0]  col_ptr   [ChipsDef];
  bit [ColW-1:0]  start_ln  [ChipsDef];
  bit             disp_on   [ChipsDef];
  bit [ByteW-1:0] out_latch [ChipsDef];

  bus_item_t      bus_q[$];
  bit [ByteW-1:0] read_exp_q[$];

  int unsigned err_cnt;
  int unsigned rsp_count;
  int unsigned cycle_cnt;
  int unsigned hold_left;
  bit          hold_done;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // apply one accepted access to the chip state, queue the read result if any
  function automatic void bus_access(bus_item_t it);
    bit [ByteW-1:0] acc;
    acc = '0;
    for (int c = 0; c < ChipsDef; c++) begin
      if (it.cs[c]) begin
        case (it.op)
          OP_CMD: begin
            if (it.data == CMD_OFF) begin
              disp_on[c] = 1'b0;
            end else if (it.data == CMD_ON) begin
              disp_on[c] = 1'b1;
            end else if ((it.data & CMD_COL_MASK) == CMD_COL) begin
              col_ptr[c] = it.data[ColW-1:0];
            end else if ((it.data & CMD_PAGE_MASK) == CMD_PAGE) begin
              page_ptr[c] = it.data[PageW-1:0];
            end else if ((it.data & CMD_COL_MASK) == CMD_START) begin
              start_ln[c] = it.data[ColW-1:0];
            end
          end
          // pointers never leave the ram at full size; column wraps at 64 by width
          OP_WRITE: begin
            lcd_ram[c][page_ptr[c]][col_ptr[c]] = it.data;
            col_ptr[c] = col_ptr[c] + 1'b1;
          end
          OP_STATUS: begin
            acc |= disp_on[c] ? 8'h00 : STATUS_OFF;
          end
          default: begin
            acc |= out_latch[c];
            out_latch[c] = lcd_ram[c][page_ptr[c]][col_ptr[c]];
            col_ptr[c] = col_ptr[c] + 1'b1;
          end
        endcase
      end
    end
    if (it.op == OP_STATUS || it.op == OP_READ) begin
      read_exp_q.push_back(acc);
    end
  endfunction

  function automatic void push_item(op_e op, logic [1:0] cs, logic [ByteW-1:0] data);
    bus_item_t it;
    it.op   = op;
    it.cs   = cs;
    it.data = data;
    bus_q.push_back(it);
  endfunction

  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, MaxWait);
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    bus_item_t   nxt;
    bus_item_t   cur;
    int unsigned gap_left;
    bit          calm;
    if (!rst_ni) begin
      req_if.valid       <= 1'b0;
      req_if.operation   <= OP_CMD;
      req_if.chip_select <= 2'b00;
      req_if.bus_byte    <= '0;
      gap_left = 0;
      calm     = 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        cur.op   = op_e'(req_if.operation);
        cur.cs   = req_if.chip_select;
        cur.data = req_if.bus_byte;
        bus_access(cur);
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left != 0) begin
          req_if.valid <= 1'b0;
          gap_left = gap_left - 1;
        end else if (bus_q.size() != 0) begin
          nxt = bus_q.pop_front();
          req_if.valid       <= 1'b1;
          req_if.operation   <= nxt.op;
          req_if.chip_select <= nxt.cs;
          req_if.bus_byte    <= nxt.data;
          // runs of back-to-back items now and then
          if ($urandom_range(0, 39) == 0) calm = !calm;
          gap_left = draw_wait(calm);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin : mon_proc
    int unsigned    stall;
    bit             calm;
    bit [ByteW-1:0] exp_byte;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_count    <= 0;
      stall = 0;
      calm  = 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_count <= rsp_count + 1;
        if (read_exp_q.size() == 0) begin
          $error("read_byte: no result expected, got %02h", rsp_if.read_byte);
          err_cnt++;
        end else begin
          exp_byte = read_exp_q.pop_front();
          if (rsp_if.read_byte !== exp_byte) begin
            $error("read_byte: expected %02h, got %02h", exp_byte, rsp_if.read_byte);
            err_cnt++;
          end
        end
        if ($urandom_range(0, 39) == 0) calm = !calm;
        stall = draw_wait(calm);
      end else if (stall != 0) begin
        stall = stall - 1;
      end
      rsp_if.ready <= (stall == 0) && (hold_left == 0);
    end
  end

  // one long hold-off on the result side so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && rsp_count >= HoldAfter) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("dual_chip_graphic_lcd_controller_tb: done, errors");
      $finish;
    end
  end

  initial begin : stim_proc
    logic [1:0]       cs;
    logic [1:0]       rd_cs;
    logic [ColW-1:0]  col;
    int unsigned      n;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.operation   = OP_CMD;
    req_if.chip_select = 2'b00;
    req_if.bus_byte    = '0;
    rsp_if.ready       = 1'b0;
    err_cnt            = 0;
    cycle_cnt          = 0;

    // directed: status after reset, on/off per chip, unknown commands,
    // pointer extremes, column wrap, latched reads, no chip and both chips
    push_item(OP_STATUS, 2'b11, 8'h00);
    push_item(OP_STATUS, 2'b00, 8'hff);
    push_item(OP_CMD,    2'b01, CMD_ON);
    push_item(OP_STATUS, 2'b01, 8'h00);
    push_item(OP_STATUS, 2'b10, 8'h00);
    push_item(OP_STATUS, 2'b11, 8'h00);
    push_item(OP_CMD,    2'b11, 8'h3d);
    push_item(OP_CMD,    2'b11, 8'h00);
    push_item(OP_CMD,    2'b11, 8'h80);
    push_item(OP_CMD,    2'b11, 8'hb7);
    push_item(OP_CMD,    2'b11, 8'hff);
    push_item(OP_CMD,    2'b11, CMD_START);
    push_item(OP_CMD,    2'b11, CMD_PAGE | 8'h07);
    push_item(OP_CMD,    2'b11, CMD_COL | 8'h3f);
    push_item(OP_WRITE,  2'b01, 8'hff);
    push_item(OP_WRITE,  2'b10, 8'h00);
    push_item(OP_WRITE,  2'b11, 8'ha5);
    push_item(OP_WRITE,  2'b00, 8'h5a);
    push_item(OP_CMD,    2'b11, CMD_COL | 8'h3f);
    push_item(OP_READ,   2'b11, 8'h00);
    push_item(OP_READ,   2'b11, 8'h00);
    push_item(OP_READ,   2'b11, 8'hff);
    push_item(OP_READ,   2'b00, 8'h00);
    push_item(OP_CMD,    2'b10, CMD_OFF);
    push_item(OP_STATUS, 2'b11, 8'h00);

    // random: mostly write-then-read-back bursts, the rest single accesses
    while (bus_q.size() < RandItems + 25) begin
      if ($urandom_range(0, 9) < 6) begin
        cs    = ($urandom_range(0, 7) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
        rd_cs = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : cs;
        col   = ColW'($urandom_range(0, ColumnsDef - 1));
        n     = $urandom_range(1, 12);
        push_item(OP_CMD, cs, CMD_PAGE | 8'($urandom_range(0, PagesDef - 1)));
        push_item(OP_CMD, cs, CMD_COL | 8'(col));
        repeat (n) push_item(OP_WRITE, cs, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) begin
          push_item(OP_CMD, cs, ($urandom_range(0, 1) != 0) ? CMD_ON : CMD_OFF);
          push_item(OP_STATUS, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
        push_item(OP_CMD, rd_cs, CMD_COL | 8'(col));
        // first read only empties the stale latch
        repeat (n + 1) push_item(OP_READ, rd_cs, 8'($urandom_range(0, 255)));
      end else begin
        push_item(op_e'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)));
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (bus_q.size() != 0 || req_if.valid);
    do @(negedge clk_i); while (read_exp_q.size() != 0);
    repeat (DrainWait) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("dual_chip_graphic_lcd_controller_tb: done, clean");
    end else begin
      $display("dual_chip_graphic_lcd_controller_tb: done, errors");
    end
    $finish;
  end

endmodule
